/* rtl/bpa_pkg.sv */
// Shared types and constants of the bitmap page allocator.
// Holds request and status codes, the controller states and the bit-search helper.
// Depends on nothing; every other file imports it.
package bpa_pkg;

   // Fixed field widths of the request and response words.
   localparam int FUNC_W     = 3;
   localparam int ADDR_W     = 32;
   localparam int PAGE_NUM_W = 15;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 16;
   localparam int MAP_BITS   = 32;
   localparam int BIT_IDX_W  = 5;

   // Request codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_AVAIL   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LATCH   = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOPAGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY,
      ST_DONE
   } state_type;

   // Encodes a one-hot word into its bit position; all bits are independent.
   function automatic logic [BIT_IDX_W-1:0] onehot_index(logic [MAP_BITS-1:0] oh);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < MAP_BITS; i++) begin
         if (oh[i]) begin
            idx = idx | BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/bitmap_page_allocator.sv */
// Bitmap page allocator: used and owned bitmaps in two synchronous memories.
// Top level of the block; imports bpa_pkg.
//
// Usage notes
// The request channel (req_*) carries one word per request: func selects
// allocate, free, reserve page, make page available or latch the total count.
// The response channel (rsp_*) returns exactly one word per request, in order,
// with the page address, a status code and the free and total page counts.
// Both channels move a word at a clock edge where valid is high and stall low.
// After reset the block runs a clearing pass over the bitmap memories, one
// word per cycle, with req_stall held high; every page then reads as used
// and none as owned. Free, reserve and make-available with a valid page do
// one read-modify-write of a bitmap word. Allocate scans the used bitmap
// one word per cycle from the word of the last hit; with no free page it
// skips the scan. Latch total and requests with an invalid page or code go
// straight to the response. One request is in work at a time, and req_stall
// falls in the same cycle that rsp_valid rises. A waiting response does not
// block the next request; only finishing that request waits while rsp_stall
// is high. PAGE_BYTES is a power of two.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [ADDR_W-1:0]     req_free_address,
   input  logic [PAGE_NUM_W-1:0] req_page_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_W-1:0]     rsp_page_address,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [COUNT_W-1:0]    rsp_free_pages,
   output logic [COUNT_W-1:0]    rsp_total_pages
);

   localparam int MAP_WORDS  = (NUM_PAGES + MAP_BITS - 1) / MAP_BITS;
   localparam int WORD_W     = $clog2(MAP_WORDS);
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PG_W       = WORD_W + BIT_IDX_W;

   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

   // Bitmap memories and their registered read data.
   logic [MAP_BITS-1:0] used_mem  [MAP_WORDS];
   logic [MAP_BITS-1:0] owned_mem [MAP_WORDS];
   logic [MAP_BITS-1:0] used_rd_ff;
   logic [MAP_BITS-1:0] owned_rd_ff;

   logic                rd_en;
   logic [WORD_W-1:0]   rd_addr;
   logic                mem_we;
   logic [WORD_W-1:0]   wr_addr;
   logic [MAP_BITS-1:0] used_wr;
   logic [MAP_BITS-1:0] owned_wr;

   // Control and datapath registers.
   state_type             state_ff, state_in;
   logic [WORD_W-1:0]     clear_idx_ff, clear_idx_in;
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic [WORD_W-1:0]     scan_word_ff, scan_word_in;
   logic [WORD_W-1:0]     data_word_ff, data_word_in;
   logic [WORD_W-1:0]     scanned_ff, scanned_in;
   logic [WORD_W-1:0]     search_ff, search_in;
   logic [CNT_W-1:0]      free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_page_address_ff, rsp_page_address_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_free_pages_ff, rsp_free_pages_in;
   logic [COUNT_W-1:0]    rsp_total_pages_ff, rsp_total_pages_in;

   // Request decode.
   logic                  free_addr_ok;
   logic [PG_W-1:0]       free_pg;
   logic                  page_in_range;
   logic                  out_free;
   logic                  scan_hit;
   logic                  scan_last;
   logic [MAP_BITS-1:0]   clear_bits;
   logic [MAP_BITS-1:0]   low_clear_oh;
   logic [MAP_BITS-1:0]   bit_mask;
   logic [PG_W-1:0]       hit_pg;

   assign free_addr_ok  = (33'(req_free_address >> PAGE_SHIFT) < 33'(NUM_PAGES)) &&
                          ((req_free_address & ADDR_W'(PAGE_BYTES - 1)) == '0);
   assign free_pg       = PG_W'(req_free_address >> PAGE_SHIFT);
   assign page_in_range = 32'(req_page_number) < 32'(NUM_PAGES);
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   // Lowest clear bit of the word under scan, as a one-hot mask.
   assign clear_bits    = ~used_rd_ff;
   assign low_clear_oh  = clear_bits & (~clear_bits + MAP_BITS'(1));
   assign scan_hit      = used_rd_ff != '1;
   assign scan_last     = scanned_ff == LAST_WORD;
   assign hit_pg        = {data_word_ff, onehot_index(low_clear_oh)};
   assign bit_mask      = MAP_BITS'(1) << bit_ff;

   // Next word of the circular scan.
   function automatic logic [WORD_W-1:0] next_word(logic [WORD_W-1:0] w);
      return (w == LAST_WORD) ? '0 : w + WORD_W'(1);
   endfunction

   // Bitmap memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_mem[wr_addr]  <= used_wr;
         owned_mem[wr_addr] <= owned_wr;
      end
      if (rd_en) begin
         used_rd_ff  <= used_mem[rd_addr];
         owned_rd_ff <= owned_mem[rd_addr];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_idx_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FUNC_ALLOC:   state_in = (free_cnt_ff == '0) ? ST_DONE : ST_SCAN;
                  FUNC_FREE:    state_in = free_addr_ok ? ST_MODIFY : ST_DONE;
                  FUNC_RESERVE,
                  FUNC_AVAIL:   state_in = page_in_range ? ST_MODIFY : ST_DONE;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_MODIFY: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the controller and next values of the datapath.
   always_comb begin
      req_stall           = state_ff != ST_IDLE;
      rd_en               = 1'b0;
      rd_addr             = scan_word_ff;
      mem_we              = 1'b0;
      wr_addr             = word_ff;
      used_wr             = used_rd_ff;
      owned_wr            = owned_rd_ff;
      clear_idx_in        = clear_idx_ff;
      func_in             = func_ff;
      word_in             = word_ff;
      bit_in              = bit_ff;
      scan_word_in        = scan_word_ff;
      data_word_in        = data_word_ff;
      scanned_in          = scanned_ff;
      search_in           = search_ff;
      free_cnt_in         = free_cnt_ff;
      total_in            = total_ff;
      pend_status_in      = pend_status_ff;
      pend_addr_in        = pend_addr_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_page_address_in = rsp_page_address_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_free_pages_in   = rsp_free_pages_ff;
      rsp_total_pages_in  = rsp_total_pages_ff;

      unique case (state_ff)
         // Sweep the memories to their reset contents.
         ST_CLEAR: begin
            mem_we       = 1'b1;
            wr_addr      = clear_idx_ff;
            used_wr      = '1;
            owned_wr     = '0;
            clear_idx_in = next_word(clear_idx_ff);
         end

         // Take a request, decode it and issue the first bitmap read if it needs one.
         ST_IDLE: begin
            if (req_valid) begin
               func_in        = req_func;
               pend_status_in = STATUS_OK;
               pend_addr_in   = '0;
               unique case (req_func)
                  FUNC_ALLOC: begin
                     rd_en        = 1'b1;
                     rd_addr      = search_ff;
                     data_word_in = search_ff;
                     scan_word_in = next_word(search_ff);
                     scanned_in   = '0;
                     if (free_cnt_ff == '0) begin
                        pend_status_in = STATUS_NOPAGE;
                     end
                  end
                  FUNC_FREE: begin
                     word_in = free_pg[PG_W-1:BIT_IDX_W];
                     bit_in  = free_pg[BIT_IDX_W-1:0];
                     rd_en   = 1'b1;
                     rd_addr = free_pg[PG_W-1:BIT_IDX_W];
                     if (!free_addr_ok) begin
                        pend_status_in = STATUS_INVALID;
                     end
                  end
                  FUNC_RESERVE,
                  FUNC_AVAIL: begin
                     word_in = WORD_W'(req_page_number >> BIT_IDX_W);
                     bit_in  = req_page_number[BIT_IDX_W-1:0];
                     rd_en   = 1'b1;
                     rd_addr = WORD_W'(req_page_number >> BIT_IDX_W);
                  end
                  FUNC_LATCH: begin
                     total_in = free_cnt_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One word per cycle: check the word that just arrived, read the next.
         ST_SCAN: begin
            rd_en        = 1'b1;
            rd_addr      = scan_word_ff;
            data_word_in = scan_word_ff;
            scan_word_in = next_word(scan_word_ff);
            scanned_in   = scanned_ff + WORD_W'(1);
            if (scan_hit) begin
               mem_we       = 1'b1;
               wr_addr      = data_word_ff;
               used_wr      = used_rd_ff | low_clear_oh;
               owned_wr     = owned_rd_ff | low_clear_oh;
               search_in    = data_word_ff;
               free_cnt_in  = free_cnt_ff - CNT_W'(1);
               pend_addr_in = ADDR_W'(64'(hit_pg) << PAGE_SHIFT);
            end else if (scan_last) begin
               pend_status_in = STATUS_NOPAGE;
            end
         end

         // Read-modify-write of one bitmap word for free, reserve and available.
         ST_MODIFY: begin
            priority case (func_ff)
               FUNC_FREE: begin
                  if ((owned_rd_ff & bit_mask) == '0) begin
                     pend_status_in = STATUS_INVALID;
                  end else begin
                     mem_we   = 1'b1;
                     owned_wr = owned_rd_ff & ~bit_mask;
                     used_wr  = used_rd_ff & ~bit_mask;
                     if ((used_rd_ff & bit_mask) != '0) begin
                        free_cnt_in = free_cnt_ff + CNT_W'(1);
                     end
                  end
               end
               FUNC_RESERVE: begin
                  if ((used_rd_ff & bit_mask) == '0) begin
                     mem_we      = 1'b1;
                     used_wr     = used_rd_ff | bit_mask;
                     free_cnt_in = free_cnt_ff - CNT_W'(1);
                  end
               end
               default: begin
                  if ((used_rd_ff & bit_mask) != '0) begin
                     mem_we      = 1'b1;
                     used_wr     = used_rd_ff & ~bit_mask;
                     free_cnt_in = free_cnt_ff + CNT_W'(1);
                  end
               end
            endcase
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_page_address_in = pend_addr_ff;
               rsp_status_in       = pend_status_ff;
               rsp_free_pages_in   = COUNT_W'(free_cnt_ff);
               rsp_total_pages_in  = COUNT_W'(total_ff);
            end
         end

         default: begin
         end
      endcase
   end

   // Register update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         search_ff    <= '0;
         free_cnt_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         search_ff    <= search_in;
         free_cnt_ff  <= free_cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff             <= func_in;
      word_ff             <= word_in;
      bit_ff              <= bit_in;
      scan_word_ff        <= scan_word_in;
      data_word_ff        <= data_word_in;
      scanned_ff          <= scanned_in;
      pend_status_ff      <= pend_status_in;
      pend_addr_ff        <= pend_addr_in;
      rsp_page_address_ff <= rsp_page_address_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_free_pages_ff   <= rsp_free_pages_in;
      rsp_total_pages_ff  <= rsp_total_pages_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_page_address_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_pages   = rsp_free_pages_ff;
   assign rsp_total_pages  = rsp_total_pages_ff;

endmodule

/* rtl/bpa_checker.sv */
// Port-level checks of the bitmap page allocator, bound to its top level.
// Imports bpa_pkg for the field widths and status codes.
// Holds the checker module and the bind statement.
module bpa_checker
   import bpa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [ADDR_W-1:0]     rsp_page_address,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [COUNT_W-1:0]    rsp_free_pages,
   input logic [COUNT_W-1:0]    rsp_total_pages
);

   // Reset starts the clearing pass: no request is taken and no word is shown.
   assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("request taken or response shown right after reset");

   // Only the three defined status codes are ever returned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NOPAGE ||
                     rsp_status == STATUS_INVALID))
      else $error("undefined status code");

   // A failed request never reports a page address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_page_address == '0)
      else $error("page address on a failed request");

   // Allocation fails only when the free count is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NOPAGE |-> rsp_free_pages == '0)
      else $error("no free page reported while pages are free");

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_page_address) &&
         $stable(rsp_status) && $stable(rsp_free_pages) && $stable(rsp_total_pages))
      else $error("stalled response word changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
